>>> rtl/ffha_pkg.sv
`default_nettype none
package ffha_pkg;
	localparam int HEAP_BYTES_D   = 65536;
	localparam int HEADER_BYTES_D = 8;
	localparam int BLOCK_BYTES_D  = 12;
	localparam int MAX_SEGMENTS_D = 64;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOFIT   = 2'd1;
	localparam logic [1:0] ST_BADFREE = 2'd2;

	typedef struct packed {
		logic        func;
		logic [16:0] req_size;
		logic [31:0] free_addr;
	} req_t;

	typedef struct packed {
		logic [31:0] data_addr;
		logic [1:0]  status;
	} rsp_t;

	// segment record travelling along the chain
	typedef struct packed {
		logic        vld;
		logic        used;
		logic [16:0] size;
	} seg_t;

	// per-cycle command broadcast from the controller to every cell
	typedef struct packed {
		logic        shift;   // cell k takes cell k-1 record
		logic        rotate;  // every cell takes its right neighbor (scan step)
		logic        wr_head; // head cell takes wr_seg
		seg_t        wr_seg;
	} cell_cmd_t;
endpackage
`default_nettype wire

>>> rtl/ffha_cell.sv
`default_nettype none
module ffha_cell (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ffha_pkg::seg_t   rst_seg,
	input  wire logic             rotate,
	input  wire ffha_pkg::seg_t   nxt_seg,
	output ffha_pkg::seg_t        seg
);
	import ffha_pkg::*;
	seg_t seg_q;
	// each step the record moves one cell toward the head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= rst_seg;
		end else if (rotate) begin
			seg_q <= nxt_seg;
		end
	end
	assign seg = seg_q;
endmodule
`default_nettype wire

>>> rtl/first_fit_heap_allocator.sv
// An allocate or free runs from start to the done strobe; one request at a time,
// busy high meanwhile.
// The segment table is a ring of cells rotated past the head cell once per cycle while busy,
// so every request walks the whole ring; that rotation sets how long a request takes.
// Reset (async, active low): one free segment of HEAP_BYTES-HEADER_BYTES, heap_base 0.
// Results are a one-cycle strobe; the receiver cannot stall.
`default_nettype none
module first_fit_heap_allocator #(
	parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_D,
	parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_D,
	parameter int BLOCK_BYTES  = ffha_pkg::BLOCK_BYTES_D,
	parameter int MAX_SEGMENTS = ffha_pkg::MAX_SEGMENTS_D
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire ffha_pkg::req_t req,
	input  wire logic           cfg_we,
	input  wire logic [31:0]    cfg_wdata,
	output logic                done,
	output ffha_pkg::rsp_t      rsp
);
	import ffha_pkg::*;
	localparam int N  = MAX_SEGMENTS;
	localparam int CW = $clog2(N + 1);
	localparam logic [16:0] SZ0 = (HEAP_BYTES >= HEADER_BYTES) ?
		17'(HEAP_BYTES - HEADER_BYTES) : 17'd0;
	localparam logic [17:0] HDR = 18'(HEADER_BYTES);
	localparam logic [17:0] BLK = 18'(BLOCK_BYTES);

	// Ring of N+1 cells; index N is a spare slot so a split can insert one record.
	// Scan: each cycle while busy, cell 0 is inspected and moved to the tail, all others move
	// toward the head. Records beyond the count are invalid and pass through.
	seg_t cell_seg [N+1];
	seg_t nxt [N+1];
	logic rot;
	seg_t ins_q;      // record delayed by one slot after a split
	logic ins_pend_q;

	genvar g;
	generate
		for (g = 0; g <= N; g++) begin : g_cell
			seg_t rs;
			always_comb begin
				rs = '0;
				if (g == 0) begin
					rs.vld = 1'b1;
					rs.size = SZ0;
				end
			end
			ffha_cell u_cell (
				.clk(clk), .arst_n(arst_n), .rst_seg(rs),
				.rotate(rot), .nxt_seg(nxt[g]), .seg(cell_seg[g])
			);
		end
	endgenerate

	logic [31:0] base_q;
	logic        busy_q;
	req_t        req_q;
	logic [CW-1:0] step_q;
	logic [CW-1:0] cnt_q;
	logic        found_q;
	logic [31:0] addr_q;
	logic [31:0] hit_addr_q;
	logic [1:0]  st_q;
	logic        done_q;
	rsp_t        rsp_q;

	// head processing
	seg_t h;
	seg_t h_new;
	seg_t tail_in;
	logic split;
	logic take;
	logic hit_free;
	logic [17:0] sz_rem;

	always_comb begin
		h = cell_seg[0];
		h_new = h;
		split = 1'b0;
		take = 1'b0;
		hit_free = 1'b0;
		sz_rem = 18'({1'b0, h.size}) - 18'({1'b0, req_q.req_size}) - HDR;
		if (busy_q && h.vld && !found_q) begin
			if (req_q.func == FUNC_ALLOC) begin
				if (!h.used && h.size >= req_q.req_size) begin
					take = 1'b1;
					h_new.used = 1'b1;
					if (!(h.size == req_q.req_size
						|| {1'b0, h.size} < {1'b0, req_q.req_size} + BLK
						|| {1'b0, h.size} < {1'b0, req_q.req_size} + HDR
						|| cnt_q >= CW'(N))) begin
						split = 1'b1;
						h_new.size = req_q.req_size;
					end
				end
			end else if (addr_q == req_q.free_addr) begin
				take = 1'b1;
				hit_free = h.used;
				h_new.used = 1'b0;
			end
		end
		// after a split every later record enters the tail one step late;
		// the first invalid record reaching the head is dropped to close the gap
		tail_in = ins_pend_q ? ins_q : h_new;
		for (int k = 0; k < N; k++) nxt[k] = cell_seg[k+1];
		nxt[N] = tail_in;
	end

	assign rot = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			busy_q <= 1'b0;
			req_q <= '0;
			step_q <= '0;
			cnt_q <= CW'(1);
			found_q <= 1'b0;
			addr_q <= '0;
			hit_addr_q <= '0;
			st_q <= ST_OK;
			ins_q <= '0;
			ins_pend_q <= 1'b0;
			done_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) base_q <= cfg_wdata;
			if (!busy_q) begin
				if (start) begin
					busy_q <= 1'b1;
					req_q <= req;
					addr_q <= base_q + 32'(HEADER_BYTES);
					step_q <= '0;
					found_q <= 1'b0;
					ins_pend_q <= 1'b0;
				end
			end else begin
				step_q <= step_q + CW'(1);
				if (h.vld) addr_q <= addr_q + 32'(HEADER_BYTES) + 32'(h.size);
				if (ins_pend_q) begin
					if (h.vld) ins_q <= h;
					else ins_pend_q <= 1'b0;
				end else if (take) begin
					found_q <= 1'b1;
					hit_addr_q <= addr_q;
					if (req_q.func == FUNC_ALLOC) st_q <= ST_OK;
					else st_q <= hit_free ? ST_OK : ST_BADFREE;
					if (split) begin
						ins_q.vld <= 1'b1;
						ins_q.used <= 1'b0;
						ins_q.size <= sz_rem[16:0];
						ins_pend_q <= 1'b1;
						cnt_q <= cnt_q + CW'(1);
					end
				end
				if (step_q == CW'(N)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					rsp_q.status <= found_q ? st_q :
						(req_q.func == FUNC_ALLOC ? ST_NOFIT : ST_BADFREE);
					rsp_q.data_addr <= (found_q && req_q.func == FUNC_ALLOC &&
						st_q == ST_OK) ? hit_addr_q : 32'd0;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rsp = rsp_q;
endmodule
`default_nettype wire
